// File: rtl/fhap_pkg.sv
package fhap_pkg;

    localparam int TAPS_DEF        = 50;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int SAMPLE_W        = 16;
    localparam int RESULT_W        = 16;
    localparam int COEF_W          = 20;
    localparam int CORDIC_STEPS    = 24;
    localparam int CORDIC_SCALE    = 24;
    localparam int TURN_W          = 32;
    localparam longint unsigned INV_PI_Q32 = 64'd1367130551;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_MAC,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SUMSQ,
        ST_ROOT,
        ST_FINISH
    } fhap_state_t;

    // atan(2^-i) in turns, 2^32 per turn
    function automatic logic [TURN_W-1:0] turn_atan(input logic [4:0] idx);
        logic [TURN_W-1:0] v;
        begin
            unique case (idx)
                5'd0:    v = 32'h20000000;
                5'd1:    v = 32'h12E4051E;
                5'd2:    v = 32'h09FB385B;
                5'd3:    v = 32'h051111D4;
                5'd4:    v = 32'h028B0D43;
                5'd5:    v = 32'h0145D7E1;
                5'd6:    v = 32'h00A2F61E;
                5'd7:    v = 32'h00517C55;
                5'd8:    v = 32'h0028BE53;
                5'd9:    v = 32'h00145F2F;
                5'd10:   v = 32'h000A2F98;
                5'd11:   v = 32'h000517CC;
                5'd12:   v = 32'h00028BE6;
                5'd13:   v = 32'h000145F3;
                5'd14:   v = 32'h0000A2F9;
                5'd15:   v = 32'h0000517C;
                5'd16:   v = 32'h000028BE;
                5'd17:   v = 32'h0000145F;
                5'd18:   v = 32'h00000A2F;
                5'd19:   v = 32'h00000517;
                5'd20:   v = 32'h0000028B;
                5'd21:   v = 32'h00000145;
                5'd22:   v = 32'h000000A2;
                5'd23:   v = 32'h00000051;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    // Q1.17 Hilbert tap k (1..taps); elaboration only, shift-subtract division
    function automatic longint kernel(input int taps, input int k);
        longint m;
        longint unsigned am;
        longint unsigned den;
        longint unsigned n;
        longint unsigned rem;
        longint unsigned q;
        begin
            m   = 2 * longint'(k) - 2 * longint'(taps >> 1) - 1;
            am  = (m < 0) ? longint'(-m) : longint'(m);
            den = am << 32;
            n   = (INV_PI_Q32 << 18) + (den >> 1);
            rem = 0;
            q   = 0;
            for (int b = 63; b >= 0; b--)
            begin
                rem = (rem << 1) | longint'(n[b]);
                q   = q << 1;
                if (rem >= den)
                begin
                    rem = rem - den;
                    q   = q | 64'd1;
                end
            end
            return (m < 0) ? -longint'(q) : longint'(q);
        end
    endfunction

endpackage

// File: rtl/fhap_cordic.sv
module fhap_cordic
    import fhap_pkg::*;
#(
    parameter int IN_W = 27
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic signed [IN_W-1:0] x_in,
    input  logic signed [IN_W-1:0] y_in,
    output logic                   done,
    output logic [RESULT_W-1:0]    angle
);

    localparam int DW = IN_W + CORDIC_SCALE + 3;

    logic signed [DW-1:0] x_reg, x_next;
    logic signed [DW-1:0] y_reg, y_next;
    logic [TURN_W-1:0]    z_reg, z_next;
    logic [4:0]           step_reg, step_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 zero_reg, zero_next;
    logic signed [DW-1:0] xs, ys, dx, dy;
    logic [TURN_W-1:0]    z_round;

    always_comb
    begin
        xs        = DW'(x_in) <<< CORDIC_SCALE;
        ys        = DW'(y_in) <<< CORDIC_SCALE;
        dx        = y_reg >>> step_reg;
        dy        = x_reg >>> step_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        zero_next = zero_reg;
        if (start)
        begin
            zero_next = (x_in == '0) && (y_in == '0);
            busy_next = 1'b1;
            done_next = 1'b0;
            step_next = '0;
            if (x_in < 0)
            begin
                x_next = -xs;
                y_next = -ys;
                z_next = 32'h80000000;
            end
            else
            begin
                x_next = xs;
                y_next = ys;
                z_next = '0;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg > 0)
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + turn_atan(step_reg);
            end
            else
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - turn_atan(step_reg);
            end
            step_next = step_reg + 5'd1;
            if (step_reg == 5'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        zero_reg <= zero_next;
    end

    assign z_round = z_reg + 32'h00008000;
    assign done    = done_reg;
    assign angle   = zero_reg ? '0 : z_round[TURN_W-1:TURN_W-RESULT_W];

endmodule

// File: rtl/fir_hilbert_amplitude_phase_core.sv
// FIR Hilbert envelope / phase / frequency core.
// Input stream s_axis_*: one signed sample per item in tdata[15:0].
// Output stream m_axis_*: one result per sample once the line of TAPS+1
// samples is full: amplitude, phase (binary angle) and phase step.
// Items that only fill the line are stored and give no result.
// A sample that completes the line starts a result item; no new sample is
// taken until that result has been loaded into the output register.
// One shared multiplier walks the sample memory one entry a cycle, then
// computes two squares; a 16-step square root then runs alongside a
// 24-step CORDIC, and the CORDIC sets the end point.
// s_axis_tready is high only while the sequencer is idle.
// Results sit in an output register; the next sample is taken while a
// result waits, and a finished result waits for the register to free up
// when the receiver stalls.
// Reset clears the fill count, last phase and control state; the sample
// memory needs no clearing since no result is made before it is full.
module fir_hilbert_amplitude_phase_core
    import fhap_pkg::*;
#(
    parameter int TAPS        = TAPS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [SAMPLE_W-1:0]   s_axis_tdata,  // [15:0] sample
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [3*RESULT_W-1:0] m_axis_tdata   // amplitude, phase_angle, inst_freq
);

    localparam int LINE_LEN = TAPS + 1;
    localparam int CENTRE   = TAPS / 2;
    localparam int AW       = $clog2(LINE_LEN);
    localparam int FW       = $clog2(LINE_LEN + 1);
    localparam int CNT_W    = $clog2((LINE_LEN + 2 > 16) ? LINE_LEN + 2 : 16);
    localparam int ACC_W    = SAMPLE_BITS + COEF_W + 9;
    localparam int XH_W     = ACC_W - 18;
    localparam int MW       = (XH_W > COEF_W) ? XH_W : COEF_W;
    localparam int PW       = 2 * MW;

    typedef logic signed [COEF_W-1:0] coef_arr_t [LINE_LEN];

    // combined weight of line entry j over both neighbouring convolutions
    function automatic coef_arr_t make_coefs();
        coef_arr_t c;
        longint    v;
        begin
            for (int j = 0; j < LINE_LEN; j++)
            begin
                v = 0;
                if (j <= TAPS - 1)
                    v = v + kernel(TAPS, TAPS - j);
                if (j >= 1)
                    v = v + kernel(TAPS, TAPS + 1 - j);
                c[j] = COEF_W'(v);
            end
            return c;
        end
    endfunction

    localparam coef_arr_t COEFS = make_coefs();

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
        return (a == AW'(LINE_LEN - 1)) ? '0 : a + AW'(1);
    endfunction

    fhap_state_t state_reg, state_next;

    logic signed [SAMPLE_BITS-1:0] mem [LINE_LEN];
    logic signed [SAMPLE_BITS-1:0] rdata_reg;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic [SAMPLE_BITS+SAMPLE_W-1:0] sample_wide;
    logic [AW-1:0]    wptr_reg, rp_reg;
    logic [FW-1:0]    fill_reg, fill_inc;
    logic [CNT_W-1:0] cnt_reg;
    logic             d1_valid_reg, p_valid_reg;
    logic [AW-1:0]    d1_idx_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_rnd;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [XH_W-1:0] xh_reg;
    logic signed [MW-1:0]   mul_a, mul_b;
    logic signed [PW-1:0]   prod_reg;
    logic [PW-1:0]          sqx_reg;
    logic [PW:0]            rad;
    logic [31:0]            rem_reg, root_reg, bit_reg;
    logic [32:0]            trial;
    logic                   sat_reg;
    logic [16:0]            root_rnd;
    logic [RESULT_W-1:0]    amp;
    logic [RESULT_W-1:0]    last_phase_reg;
    logic                   m_valid_reg;
    logic [3*RESULT_W-1:0]  m_data_reg;
    logic                   in_fire, load_out, cordic_start, cordic_done;
    logic [RESULT_W-1:0]    cordic_angle;

    assign sample_wide = {{SAMPLE_BITS{1'b0}}, s_axis_tdata};
    assign sample_in   = sample_wide[SAMPLE_BITS-1:0];
    assign in_fire     = s_axis_tvalid && s_axis_tready;
    assign fill_inc    = (fill_reg == FW'(LINE_LEN)) ? fill_reg : fill_reg + FW'(1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_fire && fill_inc == FW'(LINE_LEN))
                    state_next = ST_MAC;
            ST_MAC:
                if (cnt_reg == CNT_W'(LINE_LEN + 1))
                    state_next = ST_SQ_X;
            ST_SQ_X:   state_next = ST_SQ_Y;
            ST_SQ_Y:   state_next = ST_SUMSQ;
            ST_SUMSQ:  state_next = ST_ROOT;
            ST_ROOT:
                if (cnt_reg == CNT_W'(15))
                    state_next = ST_FINISH;
            ST_FINISH:
                if (load_out)
                    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        cordic_start  = (state_reg == ST_SQ_Y);
        load_out      = (state_reg == ST_FINISH) && cordic_done
                        && (!m_valid_reg || m_axis_tready);
    end

    // shared multiplier operand select
    always_comb
    begin
        unique case (state_reg)
            ST_SQ_X:
            begin
                mul_a = MW'(x_reg);
                mul_b = MW'(x_reg);
            end
            ST_SQ_Y:
            begin
                mul_a = MW'(xh_reg);
                mul_b = MW'(xh_reg);
            end
            default:
            begin
                mul_a = MW'(rdata_reg);
                mul_b = MW'(COEFS[d1_idx_reg]);
            end
        endcase
    end

    assign acc_rnd  = acc_reg + (ACC_W'(1) <<< 17);
    assign rad      = {1'b0, sqx_reg} + {1'b0, prod_reg};
    assign trial    = {1'b0, root_reg} + {1'b0, bit_reg};
    assign root_rnd = root_reg[16:0] + ((rem_reg > root_reg) ? 17'd1 : 17'd0);
    assign amp      = (sat_reg || root_rnd[16]) ? 16'hFFFF : root_rnd[15:0];

    always_ff @(posedge clk)
    begin
        if (in_fire)
            mem[wptr_reg] <= sample_in;
        rdata_reg <= mem[rp_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            wptr_reg       <= '0;
            fill_reg       <= '0;
            last_phase_reg <= '0;
            m_valid_reg    <= 1'b0;
            d1_valid_reg   <= 1'b0;
            p_valid_reg    <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            d1_valid_reg <= (state_reg == ST_MAC) && (cnt_reg < CNT_W'(LINE_LEN));
            p_valid_reg  <= d1_valid_reg;
            if (in_fire)
            begin
                wptr_reg <= wrap_inc(wptr_reg);
                fill_reg <= fill_inc;
            end
            if (state_next != state_reg)
                cnt_reg <= '0;
            else
                cnt_reg <= cnt_reg + CNT_W'(1);
            if (load_out)
            begin
                m_valid_reg    <= 1'b1;
                last_phase_reg <= cordic_angle;
            end
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (in_fire)
        begin
            rp_reg  <= wrap_inc(wptr_reg);
            acc_reg <= '0;
        end
        else if (state_reg == ST_MAC)
            rp_reg <= wrap_inc(rp_reg);
        d1_idx_reg <= cnt_reg[AW-1:0];
        if (p_valid_reg)
            acc_reg <= acc_reg + $signed(prod_reg[ACC_W-1:0]);
        if (d1_valid_reg && d1_idx_reg == AW'(CENTRE))
            x_reg <= rdata_reg;
        if (state_reg == ST_SQ_X)
            xh_reg <= acc_rnd[ACC_W-1:18];
        if (state_reg == ST_SQ_Y)
            sqx_reg <= prod_reg;
        if (state_reg == ST_SUMSQ)
        begin
            sat_reg  <= |rad[PW:32];
            rem_reg  <= rad[31:0];
            root_reg <= '0;
            bit_reg  <= 32'h40000000;
        end
        else if (state_reg == ST_ROOT)
        begin
            if ({1'b0, rem_reg} >= trial)
            begin
                rem_reg  <= rem_reg - trial[31:0];
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
                root_reg <= root_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
        if (load_out)
            m_data_reg <= {cordic_angle - last_phase_reg, cordic_angle, amp};
    end

    fhap_cordic #(
        .IN_W (XH_W)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .x_in  (XH_W'(x_reg)),
        .y_in  (xh_reg),
        .done  (cordic_done),
        .angle (cordic_angle)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule
